[hw/rtl/blm_pkg.sv]
package blm_pkg;

  // Field widths.
  localparam int unsigned PIN_W = 12;
  localparam int unsigned MV_W  = 16;
  localparam int unsigned PCT_W = 7;

  // Configuration port.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_LEVEL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_LEVEL  = 1'b1;

  localparam logic [MV_W-1:0] EMPTY_LEVEL_RESET = 16'd3600;
  localparam logic [MV_W-1:0] FULL_LEVEL_RESET  = 16'd8000;

  // Divider pin to battery voltage: v = pin * 11 + 20 mV.
  localparam logic [MV_W-1:0] DIVIDER_OFFSET_MV = 16'd20;

  // Dividend is (v - empty) * 100, which needs 23 bits.
  localparam int unsigned NUM_W  = 23;
  localparam int unsigned STEP_W = $clog2(NUM_W);

  localparam logic [PCT_W-1:0] FULL_PCT    = 7'd100;
  localparam logic [PCT_W-1:0] LOW_PCT     = 7'd5;
  localparam logic [PCT_W-1:0] RECOVER_PCT = 7'd10;

endpackage

[hw/rtl/blm_stream_if.sv]
interface blm_in_if;
  logic                     valid;
  logic                     ready;
  logic [blm_pkg::PIN_W-1:0] pin_millivolts;

  modport source (output valid, output pin_millivolts, input ready);
  modport sink   (input valid, input pin_millivolts, output ready);
endinterface

interface blm_out_if;
  logic                      valid;
  logic                      ready;
  logic [blm_pkg::PCT_W-1:0] charge_percent;
  logic                      low_power;

  modport source (output valid, output charge_percent, output low_power, input ready);
  modport sink   (input valid, input charge_percent, input low_power, output ready);
endinterface

[hw/rtl/battery_level_low_voltage_monitor.sv]
// Battery level and low-voltage monitor. Each item is one divider-pin sample
// in millivolts; the block forms the battery voltage as pin*11+20 mV, turns it
// into a whole charge percent between the empty and full levels (0 when full
// is not above empty) and tracks runs of low and good readings to enter and
// leave the low-power state. An accepted item passes through the prepare
// state, which forms the dividend, then the divide state, in which a shared
// restoring subtract-and-compare unit produces one quotient bit per cycle,
// and then the finish state, which clamps, updates the run counters and
// loads the output register. The block is ready again after the finish state.
// The finish state lasts as long as an earlier result still waits
// unaccepted in the output register. A new item is taken while an earlier
// result still waits in the output register. The user must write the empty
// and full levels through the plain configuration port only while the block
// is idle; the block itself does not enforce this.
module battery_level_low_voltage_monitor #(
  parameter int unsigned RUN_LIMIT = 20
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [blm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [blm_pkg::MV_W-1:0]      cfg_wdata_i,
  blm_in_if.sink                        in_if,
  blm_out_if.source                     out_if
);

  localparam int unsigned CntW = $clog2(RUN_LIMIT + 1);
  localparam logic [CntW-1:0] RunMax = CntW'(RUN_LIMIT);
  localparam logic [blm_pkg::STEP_W-1:0] LastStep = blm_pkg::STEP_W'(blm_pkg::NUM_W - 1);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StPrep = 2'd1;
  localparam logic [1:0] StDiv  = 2'd2;
  localparam logic [1:0] StFin  = 2'd3;

  logic [1:0] state_q, state_d;

  logic [blm_pkg::MV_W-1:0]   empty_q, full_q;
  logic [blm_pkg::PIN_W-1:0]  pin_q;
  logic [blm_pkg::MV_W-1:0]   span_q, span_d;
  logic [blm_pkg::MV_W-1:0]   rem_q, rem_d;
  logic [blm_pkg::NUM_W-1:0]  num_q, num_d;
  logic [blm_pkg::STEP_W-1:0] step_q, step_d;
  logic                       zero_q, zero_d;

  logic [CntW-1:0] low_cnt_q, low_cnt_d;
  logic [CntW-1:0] rec_cnt_q, rec_cnt_d;
  logic            lp_q, lp_d;

  logic                      out_valid_q;
  logic [blm_pkg::PCT_W-1:0] out_pct_q;
  logic                      out_lp_q;

  logic                      fin_fire;
  logic [blm_pkg::MV_W-1:0]  volt;
  logic [blm_pkg::MV_W-1:0]  diff;
  logic [blm_pkg::NUM_W-1:0] scaled;
  logic [blm_pkg::MV_W:0]    trial;
  logic                      fits;
  logic [blm_pkg::PCT_W-1:0] pct;

  assign in_if.ready = (state_q == StIdle);
  assign fin_fire    = (state_q == StFin) && (!out_valid_q || out_if.ready);

  assign out_if.valid          = out_valid_q;
  assign out_if.charge_percent = out_pct_q;
  assign out_if.low_power      = out_lp_q;

  // Voltage and scaled dividend by shifts and adds: 11 = 8+2+1, 100 = 64+32+4.
  assign volt = {1'b0, pin_q, 3'b000} + {3'b000, pin_q, 1'b0} + {4'b0000, pin_q}
              + blm_pkg::DIVIDER_OFFSET_MV;
  assign diff = volt - empty_q;
  assign scaled = {1'b0, diff, 6'd0} + {2'b00, diff, 5'd0} + {5'd0, diff, 2'b00};

  // One restoring division step per cycle.
  assign trial = {rem_q, num_q[blm_pkg::NUM_W-1]};
  assign fits  = (trial >= {1'b0, span_q});

  always_comb begin
    if (zero_q) begin
      pct = '0;
    end else if (num_q > blm_pkg::NUM_W'(blm_pkg::FULL_PCT)) begin
      pct = blm_pkg::FULL_PCT;
    end else begin
      pct = num_q[blm_pkg::PCT_W-1:0];
    end
  end

  always_comb begin
    state_d   = state_q;
    span_d    = span_q;
    rem_d     = rem_q;
    num_d     = num_q;
    step_d    = step_q;
    zero_d    = zero_q;
    low_cnt_d = low_cnt_q;
    rec_cnt_d = rec_cnt_q;
    lp_d      = lp_q;
    unique case (state_q)
      StIdle: begin
        if (in_if.valid) begin
          state_d = StPrep;
        end
      end
      StPrep: begin
        span_d  = full_q - empty_q;
        zero_d  = (full_q <= empty_q) || (volt <= empty_q);
        num_d   = scaled;
        rem_d   = '0;
        step_d  = '0;
        state_d = StDiv;
      end
      StDiv: begin
        rem_d  = fits ? blm_pkg::MV_W'(trial - {1'b0, span_q}) : trial[blm_pkg::MV_W-1:0];
        num_d  = {num_q[blm_pkg::NUM_W-2:0], fits};
        step_d = step_q + 1'b1;
        if (step_q == LastStep) begin
          state_d = StFin;
        end
      end
      StFin: begin
        if (fin_fire) begin
          state_d = StIdle;
          if (!lp_q) begin
            if (pct < blm_pkg::LOW_PCT) begin
              if (low_cnt_q >= RunMax) begin
                low_cnt_d = RunMax;
                lp_d      = 1'b1;
                rec_cnt_d = '0;
              end else begin
                low_cnt_d = low_cnt_q + 1'b1;
              end
            end else begin
              low_cnt_d = '0;
            end
          end else begin
            if (pct > blm_pkg::RECOVER_PCT) begin
              if (rec_cnt_q >= RunMax) begin
                rec_cnt_d = RunMax;
                lp_d      = 1'b0;
              end else begin
                rec_cnt_d = rec_cnt_q + 1'b1;
              end
            end else begin
              rec_cnt_d = '0;
            end
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      empty_q     <= blm_pkg::EMPTY_LEVEL_RESET;
      full_q      <= blm_pkg::FULL_LEVEL_RESET;
      low_cnt_q   <= '0;
      rec_cnt_q   <= '0;
      lp_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      low_cnt_q <= low_cnt_d;
      rec_cnt_q <= rec_cnt_d;
      lp_q      <= lp_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          blm_pkg::CFG_EMPTY_LEVEL: empty_q <= cfg_wdata_i;
          blm_pkg::CFG_FULL_LEVEL:  full_q  <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (fin_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    span_q <= span_d;
    rem_q  <= rem_d;
    num_q  <= num_d;
    step_q <= step_d;
    zero_q <= zero_d;
    if (in_if.valid && in_if.ready) begin
      pin_q <= in_if.pin_millivolts;
    end
    if (fin_fire) begin
      out_pct_q <= pct;
      out_lp_q  <= lp_d;
    end
  end

endmodule

[hw/rtl/blm_checker.sv]
module blm_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [blm_pkg::PCT_W-1:0] charge_percent_i,
  input logic                      low_power_i
);

  // The percent never exceeds full scale.
  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (charge_percent_i <= blm_pkg::FULL_PCT))
    else $error("charge_percent above 100");

  // One item at a time: the block is busy right after taking an item.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input ready right after an accepted item");

  // A result needs the division to run, so it never shows up in the cycle after an item is taken.
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !$rose(out_valid_i))
    else $error("result appeared too soon after an accepted item");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("output valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> ($stable(charge_percent_i) && $stable(low_power_i)))
    else $error("output item changed while stalled");

endmodule

bind battery_level_low_voltage_monitor blm_checker u_blm_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_if.valid),
  .in_ready_i       (in_if.ready),
  .out_valid_i      (out_if.valid),
  .out_ready_i      (out_if.ready),
  .charge_percent_i (out_if.charge_percent),
  .low_power_i      (out_if.low_power)
);

[tb/blm_monitor_checker.sv]
module blm_monitor_checker #(
  parameter int unsigned RUN_LIMIT = 20
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [blm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [blm_pkg::MV_W-1:0]      cfg_wdata_i,
  blm_in_if                             sample_ch,
  blm_out_if                            reading_ch,
  output int unsigned                   fail_count_o,
  output int unsigned                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DIVIDER_GAIN = 11;

  typedef struct packed {
    logic [blm_pkg::PCT_W-1:0] charge;
    logic                      low_power;
  } reading_t;

  logic [blm_pkg::MV_W-1:0] empty_mv = blm_pkg::EMPTY_LEVEL_RESET;
  logic [blm_pkg::MV_W-1:0] full_mv  = blm_pkg::FULL_LEVEL_RESET;
  logic [4:0]               low_run = '0;
  logic [4:0]               recover_run = '0;
  logic                     in_low_power = 1'b0;
  reading_t                 expected_q[$];
  int unsigned              fails = 0;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  function automatic logic [blm_pkg::PCT_W-1:0] charge_of(logic [blm_pkg::PIN_W-1:0] pin);
    int unsigned volts;
    int unsigned ratio;
    volts = int'(pin) * DIVIDER_GAIN + int'(blm_pkg::DIVIDER_OFFSET_MV);
    if (full_mv <= empty_mv || volts <= empty_mv) return '0;
    ratio = ((volts - empty_mv) * 100) / (full_mv - empty_mv);
    return (ratio > blm_pkg::FULL_PCT) ? blm_pkg::FULL_PCT : ratio[blm_pkg::PCT_W-1:0];
  endfunction

  // Runs of readings move the monitor between the normal and low-power
  // states. The low counter is left alone in low power, so it still sits at
  // the limit after recovery and one low reading drops straight back.
  function automatic reading_t next_reading(logic [blm_pkg::PIN_W-1:0] pin);
    logic [blm_pkg::PCT_W-1:0] pct;
    pct = charge_of(pin);
    if (!in_low_power) begin
      if (pct < blm_pkg::LOW_PCT) begin
        if (low_run >= RUN_LIMIT) begin
          low_run      = 5'(RUN_LIMIT);
          in_low_power = 1'b1;
          recover_run  = '0;
        end else begin
          low_run++;
        end
      end else begin
        low_run = '0;
      end
    end else begin
      if (pct > blm_pkg::RECOVER_PCT) begin
        if (recover_run >= RUN_LIMIT) begin
          recover_run  = 5'(RUN_LIMIT);
          in_low_power = 1'b0;
        end else begin
          recover_run++;
        end
      end else begin
        recover_run = '0;
      end
    end
    return '{charge: pct, low_power: in_low_power};
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    reading_t got;
    reading_t want;
    if (!rst_ni) begin
      empty_mv     = blm_pkg::EMPTY_LEVEL_RESET;
      full_mv      = blm_pkg::FULL_LEVEL_RESET;
      low_run      = '0;
      recover_run  = '0;
      in_low_power = 1'b0;
      expected_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          blm_pkg::CFG_EMPTY_LEVEL: empty_mv = cfg_wdata_i;
          blm_pkg::CFG_FULL_LEVEL:  full_mv  = cfg_wdata_i;
          default: ;
        endcase
      end
      // Results are checked before the new item is queued, since an item
      // accepted at this edge cannot already have left the block.
      if (reading_ch.valid && reading_ch.ready) begin
        got = '{charge: reading_ch.charge_percent, low_power: reading_ch.low_power};
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, charge_percent %0d low_power %0b",
                   $time, got.charge, got.low_power);
          fails++;
        end else begin
          want = expected_q.pop_front();
          if (got.charge !== want.charge) begin
            $display("%0t: charge_percent expected %0d, actual %0d",
                     $time, want.charge, got.charge);
            fails++;
          end
          if (got.low_power !== want.low_power) begin
            $display("%0t: low_power expected %0b, actual %0b",
                     $time, want.low_power, got.low_power);
            fails++;
          end
        end
      end
      if (sample_ch.valid && sample_ch.ready) begin
        expected_q.push_back(next_reading(sample_ch.pin_millivolts));
      end
    end
    fail_count_o <= fails;
    pending_o    <= expected_q.size();
  end

endmodule

[tb/tb_battery_level_low_voltage_monitor.sv]
module tb_battery_level_low_voltage_monitor;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RUN_LIMIT    = 20;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_ITEMS  = 77;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned SETTLE_TICKS = 30;
  localparam int unsigned PIN_MAX      = 4095;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [blm_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [blm_pkg::MV_W-1:0]      cfg_wdata;

  blm_in_if  sample_ch ();
  blm_out_if reading_ch ();

  int unsigned fails;
  int unsigned pending;

  bit                       bursty = 1'b1;
  int unsigned              hold_asked = 0;
  int unsigned              sent_count = 0;
  logic [blm_pkg::MV_W-1:0] cur_empty = blm_pkg::EMPTY_LEVEL_RESET;
  logic [blm_pkg::MV_W-1:0] cur_full  = blm_pkg::FULL_LEVEL_RESET;

  // Under the reset levels: both ends of the pin range, the empty and full
  // crossings, the 5 and 10 percent thresholds, and alternating bit patterns.
  logic [blm_pkg::PIN_W-1:0] corner_pins [14] = '{
    12'd0, 12'd4095, 12'd325, 12'd326, 12'd345, 12'd346, 12'd365,
    12'd366, 12'd370, 12'd725, 12'd726, 12'd1365, 12'd2730, 12'd2048
  };

  battery_level_low_voltage_monitor #(
    .RUN_LIMIT (RUN_LIMIT)
  ) uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_if       (sample_ch),
    .out_if      (reading_ch)
  );

  blm_monitor_checker #(
    .RUN_LIMIT (RUN_LIMIT)
  ) checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .sample_ch    (sample_ch),
    .reading_ch   (reading_ch),
    .fail_count_o (fails),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #15ms;
    $display("Some tests failed");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Pin reading that gives a battery voltage at or just below mv.
  function automatic int unsigned pin_at_mv(int unsigned mv);
    if (mv <= int'(blm_pkg::DIVIDER_OFFSET_MV)) return 0;
    return ((mv - blm_pkg::DIVIDER_OFFSET_MV) / 11 > PIN_MAX)
           ? PIN_MAX : (mv - blm_pkg::DIVIDER_OFFSET_MV) / 11;
  endfunction

  task automatic send_sample(input logic [blm_pkg::PIN_W-1:0] pin);
    int unsigned gap;
    gap = bursty ? pick_gap() : 0;
    if (gap != 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid          <= 1'b1;
    sample_ch.pin_millivolts <= pin;
    do @(posedge clk); while (!sample_ch.ready);
    sent_count++;
  endtask

  // Mostly long runs of low or good readings, so that the low-power state is
  // entered and left; the rest are short middle readings and noise.
  task automatic send_run();
    int unsigned span;
    int unsigned low_top;
    int unsigned good_base;
    int unsigned kind;
    int unsigned len;
    span      = (cur_full > cur_empty) ? cur_full - cur_empty : 0;
    low_top   = pin_at_mv(cur_empty + span * 4 / 100);
    good_base = pin_at_mv(cur_empty + span * 12 / 100) + 1;
    if (good_base > PIN_MAX) good_base = PIN_MAX;
    kind = $urandom_range(0, 99);
    if (kind < 35) begin
      len = $urandom_range(18, 26);
      repeat (len) send_sample(blm_pkg::PIN_W'($urandom_range(0, low_top)));
    end else if (kind < 70) begin
      len = $urandom_range(18, 26);
      repeat (len) send_sample(blm_pkg::PIN_W'($urandom_range(good_base, PIN_MAX)));
    end else if (kind < 85) begin
      len = $urandom_range(1, 4);
      repeat (len) send_sample(blm_pkg::PIN_W'($urandom_range(low_top, good_base)));
    end else begin
      len = $urandom_range(1, 3);
      repeat (len) send_sample(blm_pkg::PIN_W'($urandom_range(0, PIN_MAX)));
    end
  endtask

  task automatic drain();
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic set_levels(input logic [blm_pkg::MV_W-1:0] empty_mv,
                            input logic [blm_pkg::MV_W-1:0] full_mv);
    cfg_we    <= 1'b1;
    cfg_idx   <= blm_pkg::CFG_EMPTY_LEVEL;
    cfg_wdata <= empty_mv;
    @(posedge clk);
    cfg_idx   <= blm_pkg::CFG_FULL_LEVEL;
    cfg_wdata <= full_mv;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_empty = empty_mv;
    cur_full  = full_mv;
  endtask

  // Result side: random stalls, plus one long hold-off on request while the
  // sender keeps offering items.
  initial begin
    int unsigned stall;
    int unsigned hold_served;
    stall       = 0;
    hold_served = 0;
    reading_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_asked != hold_served) begin
        hold_served++;
        reading_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        reading_ch.ready <= 1'b1;
      end else if (stall != 0) begin
        reading_ch.ready <= 1'b0;
        stall--;
      end else begin
        reading_ch.ready <= 1'b1;
        stall = bursty ? pick_gap() : 0;
      end
    end
  end

  initial begin
    int unsigned              target;
    logic [blm_pkg::MV_W-1:0] empty_mv;
    logic [blm_pkg::MV_W-1:0] full_mv;
    rst_n                    <= 1'b0;
    cfg_we                   <= 1'b0;
    cfg_idx                  <= blm_pkg::CFG_EMPTY_LEVEL;
    cfg_wdata                <= '0;
    sample_ch.valid          <= 1'b0;
    sample_ch.pin_millivolts <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (corner_pins[i]) send_sample(corner_pins[i]);

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase != 0) begin
        sample_ch.valid <= 1'b0;
        drain();
        case (phase)
          1: begin empty_mv = 16'd0;     full_mv = 16'hFFFF; end
          2: begin empty_mv = 16'hFFFF;  full_mv = 16'd0;    end
          3: begin empty_mv = 16'd5000;  full_mv = 16'd5000; end
          6: begin empty_mv = 16'd0;     full_mv = 16'd1;    end
          7: begin
            empty_mv = blm_pkg::MV_W'($urandom());
            full_mv  = blm_pkg::MV_W'($urandom());
          end
          default: begin
            empty_mv = blm_pkg::MV_W'($urandom_range(0, 40000));
            full_mv  = blm_pkg::MV_W'(empty_mv + $urandom_range(200, 20000));
          end
        endcase
        set_levels(empty_mv, full_mv);
      end
      bursty = (phase % 3) != 2;
      if (phase == 4) begin
        bursty = 1'b0;
        hold_asked <= hold_asked + 1;
      end
      target = sent_count + PHASE_ITEMS;
      while (sent_count < target) send_run();
    end

    sample_ch.valid <= 1'b0;
    drain();
    repeat (SETTLE_TICKS) @(posedge clk);
    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
